### design/ata_pkg.sv
package ata_pkg;

    // Fixed field widths of the result item
    localparam int ANGLE_W = 16;
    localparam int LANES   = 2;
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;

    // Angle accumulator: 2^-32 rad units, covers +/- (sum of the table) with margin
    localparam int TAB_FRAC = 32;
    localparam int TAB_W    = 32;
    localparam int TAB_LEN  = 28;
    localparam int ACC_W    = 35;

    // pi/2 in 2^-32 rad units (twice the rounded pi/4 entry)
    localparam logic [63:0] HALF_PI_2P32 = 64'd6746518852;

    // atan(2^-i) * 2^32, rounded to nearest
    localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072,
        32'd65536,      32'd32768,      32'd16384,      32'd8192,
        32'd4096,       32'd2048,       32'd1024,       32'd512,
        32'd256,        32'd128,        32'd64,         32'd32
    };

    // Per-angle control carried along the cell row
    typedef struct packed {
        logic bypass;   // result forced, rotation ignored
        logic lim;      // forced to +/- pi/2 (else forced to zero)
        logic neg;      // sign of the forced pi/2
        logic undef;    // numerator and denominator both zero
    } t_lane_ctl;

    typedef t_lane_ctl [LANES-1:0] t_tilt_ctl;

endpackage

### design/ata_prep.sv
module ata_prep
    import ata_pkg::*;
#(
    parameter int SW = 16,
    parameter int F  = 16,
    parameter int W  = 35
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic signed [SW-1:0] i_x,
    input  logic signed [SW-1:0] i_y,
    input  logic signed [SW-1:0] i_z,
    output logic                o_valid,
    output t_tilt_ctl           o_ctl,
    output logic signed [W-1:0] o_x [LANES],
    output logic signed [W-1:0] o_y [LANES]
);

    logic                r_valid;
    t_tilt_ctl           r_ctl;
    t_tilt_ctl           n_ctl;
    logic signed [W-1:0] r_x [LANES];
    logic signed [W-1:0] r_y [LANES];
    logic signed [W-1:0] n_x [LANES];
    logic signed [W-1:0] n_y [LANES];

    always_comb begin
        logic signed [SW:0] num;
        logic signed [SW:0] den;
        logic signed [SW:0] nn;
        logic signed [SW:0] dd;
        for (int k = 0; k < LANES; k++) begin
            num = (k == LANE_ROLL) ? {i_x[SW-1], i_x} : {i_y[SW-1], i_y};
            den = {i_z[SW-1], i_z};
            // fold the sign of z into the numerator so the denominator is >= 0
            nn = den[SW] ? -num : num;
            dd = den[SW] ? -den : den;
            n_ctl[k].bypass = (nn == '0) || (dd == '0);
            n_ctl[k].lim    = (nn != '0) && (dd == '0);
            n_ctl[k].neg    = nn[SW];
            n_ctl[k].undef  = (nn == '0) && (dd == '0);
            n_x[k] = W'(dd) <<< F;
            n_y[k] = W'(nn) <<< F;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl <= n_ctl;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

### design/ata_cell.sv
module ata_cell
    import ata_pkg::*;
#(
    parameter int W     = 35,
    parameter int STAGE = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  t_tilt_ctl               i_ctl,
    input  logic signed [W-1:0]     i_x   [LANES],
    input  logic signed [W-1:0]     i_y   [LANES],
    input  logic signed [ACC_W-1:0] i_acc [LANES],
    output logic                    o_valid,
    output t_tilt_ctl               o_ctl,
    output logic signed [W-1:0]     o_x   [LANES],
    output logic signed [W-1:0]     o_y   [LANES],
    output logic signed [ACC_W-1:0] o_acc [LANES]
);

    localparam logic signed [ACC_W-1:0] ANG =
        $signed({{(ACC_W-TAB_W){1'b0}}, ATAN_TAB[STAGE]});

    logic                    r_valid;
    t_tilt_ctl               r_ctl;
    logic signed [W-1:0]     r_x   [LANES];
    logic signed [W-1:0]     r_y   [LANES];
    logic signed [ACC_W-1:0] r_acc [LANES];
    logic signed [W-1:0]     n_x   [LANES];
    logic signed [W-1:0]     n_y   [LANES];
    logic signed [ACC_W-1:0] n_acc [LANES];

    // One vectoring micro-rotation per lane; residual y >= 0 turns clockwise
    always_comb begin
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        for (int k = 0; k < LANES; k++) begin
            xs = i_x[k] >>> STAGE;
            ys = i_y[k] >>> STAGE;
            if (!i_y[k][W-1]) begin
                n_x[k]   = i_x[k] + ys;
                n_y[k]   = i_y[k] - xs;
                n_acc[k] = i_acc[k] + ANG;
            end else begin
                n_x[k]   = i_x[k] - ys;
                n_y[k]   = i_y[k] + xs;
                n_acc[k] = i_acc[k] - ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl <= i_ctl;
            r_x   <= n_x;
            r_y   <= n_y;
            r_acc <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;

endmodule

### design/ata_post.sv
module ata_post
    import ata_pkg::*;
#(
    parameter int AFB = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  t_tilt_ctl               i_ctl,
    input  logic signed [ACC_W-1:0] i_acc [LANES],
    output logic                    o_valid,
    output logic [ANGLE_W-1:0]      o_roll,
    output logic [ANGLE_W-1:0]      o_pitch,
    output logic [LANES-1:0]        o_undef
);

    localparam int SH = TAB_FRAC - AFB;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'd1 << (SH - 1));
    localparam logic signed [ACC_W-1:0] LIM =
        ACC_W'((HALF_PI_2P32 + (64'd1 << (SH - 1))) >> SH);

    logic                     r_valid;
    logic [ANGLE_W-1:0]       r_ang [LANES];
    logic [LANES-1:0]         r_undef;
    logic [ANGLE_W-1:0]       n_ang [LANES];
    logic [LANES-1:0]         n_undef;

    // Round half up to the output grid, clamp to +/- pi/2, apply forced results
    always_comb begin
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-1:0] ang;
        for (int k = 0; k < LANES; k++) begin
            rnd = (i_acc[k] + RND) >>> SH;
            if (rnd > LIM) begin
                ang = LIM;
            end else if (rnd < -LIM) begin
                ang = -LIM;
            end else begin
                ang = rnd;
            end
            if (i_ctl[k].bypass) begin
                ang = i_ctl[k].lim ? (i_ctl[k].neg ? -LIM : LIM) : '0;
            end
            n_ang[k]   = ang[ANGLE_W-1:0];
            n_undef[k] = i_ctl[k].undef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ang   <= n_ang;
            r_undef <= n_undef;
        end
    end

    assign o_valid = r_valid;
    assign o_roll  = r_ang[LANE_ROLL];
    assign o_pitch = r_ang[LANE_PITCH];
    assign o_undef = r_undef;

endmodule

### design/accel_tilt_angles_core.sv
// Channel   Dir  tdata (low bit up)                          tuser (low bit up)
// s_axis    in   accel_x, accel_y, accel_z, zero pad to byte  -
// m_axis    out  roll_angle, pitch_angle                      roll_undefined,
//                                                             pitch_undefined
//
// One item per cycle while m_axis does not hold the row; registers in order: input fold
// register, one CORDIC cell per iteration, rounding/output register.
// Reset clears only the valid bits of the row; no clearing pass.
// When a result waits on m_axis, the whole row holds and s_axis tready drops;
// bubbles inside the row are not squeezed out while it holds.
module accel_tilt_angles_core
    import ata_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int ANGLE_FRAC_BITS = 14,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // accel_x, accel_y, accel_z, zero pad
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]        i_s_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    // roll_angle, pitch_angle
    output logic [2*ANGLE_W-1:0]                       o_m_axis_tdata,
    // roll_undefined, pitch_undefined
    output logic [LANES-1:0]                           o_m_axis_tuser
);

    localparam int SW = SAMPLE_WIDTH;
    // align the sample msb near bit 60 so every CORDIC shift floors at a fixed place
    localparam int F  = 60 - SAMPLE_WIDTH;
    // sign, folded |z| up to 2^(SW-1), CORDIC growth below 4x, F fraction bits
    localparam int W  = SW + 3 + F;

    logic                    w_adv;
    logic                    w_vld [CORDIC_STAGES+1];
    t_tilt_ctl               w_ctl [CORDIC_STAGES+1];
    logic signed [W-1:0]     w_x   [CORDIC_STAGES+1][LANES];
    logic signed [W-1:0]     w_y   [CORDIC_STAGES+1][LANES];
    logic signed [ACC_W-1:0] w_acc [CORDIC_STAGES+1][LANES];
    logic [ANGLE_W-1:0]      w_roll;
    logic [ANGLE_W-1:0]      w_pitch;

    assign w_adv           = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    ata_prep #(
        .SW (SW),
        .F  (F),
        .W  (W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata[SW-1:0]),
        .i_y     (i_s_axis_tdata[2*SW-1:SW]),
        .i_z     (i_s_axis_tdata[3*SW-1:2*SW]),
        .o_valid (w_vld[0]),
        .o_ctl   (w_ctl[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0])
    );

    assign w_acc[0][LANE_ROLL]  = '0;
    assign w_acc[0][LANE_PITCH] = '0;

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
        ata_cell #(
            .W     (W),
            .STAGE (s)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_vld[s]),
            .i_ctl   (w_ctl[s]),
            .i_x     (w_x[s]),
            .i_y     (w_y[s]),
            .i_acc   (w_acc[s]),
            .o_valid (w_vld[s+1]),
            .o_ctl   (w_ctl[s+1]),
            .o_x     (w_x[s+1]),
            .o_y     (w_y[s+1]),
            .o_acc   (w_acc[s+1])
        );
    end

    ata_post #(
        .AFB (ANGLE_FRAC_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_vld[CORDIC_STAGES]),
        .i_ctl   (w_ctl[CORDIC_STAGES]),
        .i_acc   (w_acc[CORDIC_STAGES]),
        .o_valid (o_m_axis_tvalid),
        .o_roll  (w_roll),
        .o_pitch (w_pitch),
        .o_undef (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {w_pitch, w_roll};

`ifndef SYNTH
    // An undefined angle is always reported as zero
    a_roll_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[LANE_ROLL]) |->
            (o_m_axis_tdata[ANGLE_W-1:0] == '0))
        else $error("roll undefined with nonzero angle");

    a_pitch_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[LANE_PITCH]) |->
            (o_m_axis_tdata[2*ANGLE_W-1:ANGLE_W] == '0))
        else $error("pitch undefined with nonzero angle");

    // An undefined roll control in the last cell reaches the output with its flag intact
    a_ctl_to_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_vld[CORDIC_STAGES] && w_ctl[CORDIC_STAGES][LANE_ROLL].undef) |=>
            (o_m_axis_tvalid && o_m_axis_tuser[LANE_ROLL]))
        else $error("roll undefined flag lost at output register");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ata_pkg::*;

    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 14;
    localparam int CORDIC_N    = 16;
    localparam int LATENCY     = CORDIC_N + 2;
    localparam int HOLD_CYCLES = 250;
    localparam int CYCLE_LIMIT = 200000;

    // atan(2^-i) in 2^-32 rad units, rounded to nearest
    localparam longint ATAN_STEP [CORDIC_N] = '{
        64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
        64'sd268086748,  64'sd134174063,  64'sd67103403,   64'sd33553749,
        64'sd16777131,   64'sd8388597,    64'sd4194303,    64'sd2097152,
        64'sd1048576,    64'sd524288,     64'sd262144,     64'sd131072
    };
    localparam int     ROUND_SH  = 32 - FRAC_W;
    localparam longint HALF_PI_Q =
        (64'sd6746518852 + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;

    typedef struct {
        int                        seq;
        logic signed [SAMPLE_W-1:0] ax, ay, az;
        logic signed [ANGLE_W-1:0]  roll, pitch;
        logic                       roll_undef, pitch_undef;
    } t_tilt_exp;

    logic                                i_clk;
    logic                                i_rst_n         = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [((3*SAMPLE_W+7)/8)*8-1:0]     i_s_axis_tdata  = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [2*ANGLE_W-1:0]                o_m_axis_tdata;
    logic [LANES-1:0]                    o_m_axis_tuser;

    t_tilt_exp pending_angles [$];
    int    mismatch_count    = 0;
    int    sample_count      = 0;
    int    result_count      = 0;
    int    cycle_count       = 0;
    int    sender_idle_pct   = 0;
    int    receiver_stall_pct = 0;
    logic  receiver_held     = 1'b0;
    event  hold_receiver;

    accel_tilt_angles_core #(
        .SAMPLE_WIDTH    (SAMPLE_W),
        .ANGLE_FRAC_BITS (FRAC_W),
        .CORDIC_STAGES   (CORDIC_N)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // accel_x, accel_y, accel_z
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // roll_angle, pitch_angle
        .o_m_axis_tuser  (o_m_axis_tuser)   // roll_undefined, pitch_undefined
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // atan2(num * sign(den), |den|) by vectoring rotation, in 2^-FRAC_W rad
    function automatic logic signed [ANGLE_W-1:0] tilt_angle_q(
        input longint num, input longint den, output logic undef);
        longint n, d, cx, cy, xs, ys, acc, r;
        n     = (den < 0) ? -num : num;
        d     = (den < 0) ? -den : den;
        undef = 1'b0;
        if (n == 0) begin
            undef = (d == 0);
            return '0;
        end
        if (d == 0) begin
            r = (n > 0) ? HALF_PI_Q : -HALF_PI_Q;
            return r[ANGLE_W-1:0];
        end
        cx  = d * (64'sd1 <<< (60 - SAMPLE_W));
        cy  = n * (64'sd1 <<< (60 - SAMPLE_W));
        acc = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy >= 0) begin
                cx  = cx + ys;
                cy  = cy - xs;
                acc = acc + ATAN_STEP[i];
            end else begin
                cx  = cx - ys;
                cy  = cy + xs;
                acc = acc - ATAN_STEP[i];
            end
        end
        r = (acc + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (r > HALF_PI_Q)  r = HALF_PI_Q;
        if (r < -HALF_PI_Q) r = -HALF_PI_Q;
        return r[ANGLE_W-1:0];
    endfunction

    function automatic t_tilt_exp predict_tilt(input logic signed [SAMPLE_W-1:0] ax, ay, az);
        t_tilt_exp t;
        t.seq   = sample_count;
        t.ax    = ax;
        t.ay    = ay;
        t.az    = az;
        t.roll  = tilt_angle_q(longint'(ax), longint'(az), t.roll_undef);
        t.pitch = tilt_angle_q(longint'(ay), longint'(az), t.pitch_undef);
        return t;
    endfunction

    // Mix full-range values with small, zero and extreme ones
    function automatic logic signed [SAMPLE_W-1:0] pick_axis();
        int mode;
        logic signed [SAMPLE_W-1:0] v;
        mode = $urandom_range(99);
        v    = SAMPLE_W'($urandom);
        if (mode < 50) return v;
        if (mode < 62) return SAMPLE_W'(int'($urandom_range(8)) - 4);
        if (mode < 70) return '0;
        if (mode < 80) begin
            case ($urandom_range(3))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return 16'sh8001;
                default: return 16'sh0001;
            endcase
        end
        return v >>> $urandom_range(15);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax, ay, az);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {az, ay, ax};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_angles.push_back(predict_tilt(ax, ay, az));
        sample_count++;
    endtask

    // Lower valid, wait for every result, then let the row empty
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic test_special_cases();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_sample(16'sd0, 16'sd0, 16'sd0);            // both angles undefined
        send_sample(16'sd5, -16'sd3, 16'sd0);           // z zero: +/- pi/2
        send_sample(-16'sd5, 16'sd3, 16'sd0);
        send_sample(16'sd0, 16'sd7, 16'sd0);            // roll undefined, pitch pi/2
        send_sample(16'sh8000, 16'sd0, 16'sd0);         // pitch undefined
        send_sample(16'sd0, 16'sd0, 16'sd100);          // zero numerator
        send_sample(16'sd0, 16'sd0, -16'sd100);
        send_sample(16'sd0, 16'sd0, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000, 16'sd1);      // near saturation
        send_sample(16'sh8000, 16'sh7fff, -16'sd1);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);   // most negative z
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);   // pi/4
        send_sample(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_sample(16'sd1, -16'sd1, 16'sh7fff);        // tiny angles
        send_sample(16'sd1, -16'sd1, 16'sh8000);
        send_sample(16'sd100, -16'sd100, -16'sd100);
        send_sample(16'sh7fff, 16'sh8000, 16'sh8001);
        send_sample(16'sh5555, 16'shaaaa, 16'sh00ff);
        send_sample(16'shaaaa, 16'sh5555, 16'shff00);
        send_sample(16'sd1, 16'sd0, 16'sd0);
        drain_results();
    endtask

    task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n) send_sample(pick_axis(), pick_axis(), pick_axis());
        drain_results();
    endtask

    // Block the output long enough for the row to fill and stall the input
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        -> hold_receiver;
        repeat (80) send_sample(pick_axis(), pick_axis(), pick_axis());
        drain_results();
    endtask

    initial begin : receiver_hold
        forever begin
            @(hold_receiver);
            receiver_held <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            receiver_held <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= !receiver_held && ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        t_tilt_exp want;
        logic signed [ANGLE_W-1:0] got_roll, got_pitch;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_roll  = o_m_axis_tdata[ANGLE_W-1:0];
            got_pitch = o_m_axis_tdata[2*ANGLE_W-1:ANGLE_W];
            if (pending_angles.size() == 0) begin
                report_mismatch($sformatf("result %0d with no sample pending", result_count));
            end else begin
                want = pending_angles.pop_front();
                if (got_roll !== want.roll)
                    report_mismatch($sformatf("item %0d (%0d,%0d,%0d) roll %0d, want %0d",
                        want.seq, want.ax, want.ay, want.az, got_roll, want.roll));
                if (got_pitch !== want.pitch)
                    report_mismatch($sformatf("item %0d (%0d,%0d,%0d) pitch %0d, want %0d",
                        want.seq, want.ax, want.ay, want.az, got_pitch, want.pitch));
                if (o_m_axis_tuser[LANE_ROLL] !== want.roll_undef)
                    report_mismatch($sformatf("item %0d roll_undefined %b, want %b",
                        want.seq, o_m_axis_tuser[LANE_ROLL], want.roll_undef));
                if (o_m_axis_tuser[LANE_PITCH] !== want.pitch_undef)
                    report_mismatch($sformatf("item %0d pitch_undefined %b, want %b",
                        want.seq, o_m_axis_tuser[LANE_PITCH], want.pitch_undef));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        test_random_phase(360, 0, 0);
        test_random_phase(360, 61, 0);
        test_random_phase(360, 0, 61);
        test_random_phase(360, 22, 22);
        test_backpressure();
        repeat (LATENCY) @(posedge i_clk);
        if (pending_angles.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_angles.size()));
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
